/* rtl/dwrm_pkg.sv */
// Shared types and constants for the distance weighted range minimum block.
`default_nettype none

package dwrm_pkg;

  localparam int POS_W   = 11;
  localparam int PRICE_W = 30;
  localparam int COST_W  = 31;
  localparam int SIZE_W  = 11;
  localparam int VAL_W   = 32;

  localparam logic [SIZE_W-1:0]       SIZE_RESET = 11'd1024;
  localparam logic signed [VAL_W-1:0] EMPTY_MARK = 32'sh7FFF_FFFF;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [POS_W-1:0]   position;
    logic [PRICE_W-1:0] price;
  } dwrm_in_t;

  typedef struct packed {
    logic [COST_W-1:0] best_cost;
    logic              no_answer;
  } dwrm_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic upd_step;
    logic qry_step;
    logic out_load;
  } dwrm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic in_range;
    logic at_root;
    logic qry_active;
  } dwrm_stat_t;

  function automatic logic signed [VAL_W-1:0] min_val(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

/* rtl/dwrm_tree_mem.sv */
// Tree node memory: one write port, two registered read ports.
`default_nettype none

module dwrm_tree_mem import dwrm_pkg::*; #(
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic signed [VAL_W-1:0] wdata,
  input  wire logic [AW-1:0]           raddr0,
  input  wire logic [AW-1:0]           raddr1,
  output logic signed [VAL_W-1:0]      rdata0_r,
  output logic signed [VAL_W-1:0]      rdata1_r
);

  logic signed [VAL_W-1:0] mem [DEPTH];

  // Write one node, read two nodes
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

endmodule

`default_nettype wire

/* rtl/dwrm_datapath.sv */
// Datapath: both minimum trees, path update, range walk and result forming.
`default_nettype none

module dwrm_datapath import dwrm_pkg::*; #(
  parameter int MAX_POSITIONS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [SIZE_W-1:0] cfg_data,
  input  wire dwrm_in_t          in_data,
  input  wire dwrm_cmd_t         cmd,
  output dwrm_stat_t             stat,
  output dwrm_out_t              out_data
);

  localparam int LEAF_W = $clog2(MAX_POSITIONS);
  localparam int IDX_W  = LEAF_W + 1;
  localparam int BW     = IDX_W + 1;
  localparam int NW     = LEAF_W + 1;
  localparam int NODES  = 2 * MAX_POSITIONS;
  localparam int SUM_W  = VAL_W + 2;

  logic [SIZE_W-1:0]       size_r;
  logic [IDX_W-1:0]        clr_cnt_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    first_r;
  logic signed [VAL_W-1:0] vl_r, vr_r;
  logic [BW-1:0]           al_r, bl_r, ar_r, br_r;
  logic signed [VAL_W-1:0] bestl_r, bestr_r;
  logic                    pl0_r, pl1_r, pr0_r, pr1_r;
  logic [POS_W-1:0]        qpos_r;
  dwrm_out_t               out_r;

  logic [NW-1:0]           n_act;
  logic                    in_range;
  logic [BW-1:0]           leaf;
  logic                    act_l, act_r;
  logic                    rdl0_v, rdl1_v, rdr0_v, rdr1_v;
  logic signed [VAL_W-1:0] rdl0, rdl1, rdr0, rdr1;
  logic signed [VAL_W-1:0] wval_l, wval_r;
  logic                    mem_we;
  logic [IDX_W-1:0]        waddr, sib_addr;
  logic [IDX_W-1:0]        raddr_l0, raddr_l1, raddr_r0, raddr_r1;
  logic signed [VAL_W-1:0] wdata_l, wdata_r;
  logic signed [SUM_W-1:0] cand_l, cand_r, cand_best;
  logic                    have_l, have_r;

  // Active size and range check of the incoming request
  always_comb begin
    n_act    = (32'(size_r) > 32'(MAX_POSITIONS)) ? NW'(MAX_POSITIONS) : NW'(size_r);
    in_range = (in_data.position != '0) && (32'(in_data.position) <= 32'(n_act));
    leaf     = BW'(MAX_POSITIONS) + BW'(in_data.position) - BW'(1);
  end

  // Range walk reads: left end when odd, right end minus one when odd
  always_comb begin
    act_l  = al_r < bl_r;
    act_r  = ar_r < br_r;
    rdl0_v = cmd.qry_step & act_l & al_r[0];
    rdl1_v = cmd.qry_step & act_l & bl_r[0];
    rdr0_v = cmd.qry_step & act_r & ar_r[0];
    rdr1_v = cmd.qry_step & act_r & br_r[0];
  end

  // Path update value: leaf first, then minimum with the sibling read
  always_comb begin
    wval_l = first_r ? vl_r : min_val(vl_r, rdl0);
    wval_r = first_r ? vr_r : min_val(vr_r, rdr0);
  end

  // Memory port selection
  always_comb begin
    sib_addr = idx_r ^ IDX_W'(1);
    mem_we   = cmd.clr_step | cmd.upd_step;
    waddr    = cmd.clr_step ? clr_cnt_r : idx_r;
    wdata_l  = cmd.clr_step ? EMPTY_MARK : wval_l;
    wdata_r  = cmd.clr_step ? EMPTY_MARK : wval_r;
    raddr_l0 = cmd.upd_step ? sib_addr : IDX_W'(al_r);
    raddr_r0 = cmd.upd_step ? sib_addr : IDX_W'(ar_r);
    raddr_l1 = IDX_W'(bl_r - BW'(1));
    raddr_r1 = IDX_W'(br_r - BW'(1));
  end

  dwrm_tree_mem #(.DEPTH(NODES), .AW(IDX_W)) u_left (
    .clk      (clk),
    .we       (mem_we),
    .waddr    (waddr),
    .wdata    (wdata_l),
    .raddr0   (raddr_l0),
    .raddr1   (raddr_l1),
    .rdata0_r (rdl0),
    .rdata1_r (rdl1)
  );

  dwrm_tree_mem #(.DEPTH(NODES), .AW(IDX_W)) u_right (
    .clk      (clk),
    .we       (mem_we),
    .waddr    (waddr),
    .wdata    (wdata_r),
    .raddr0   (raddr_r0),
    .raddr1   (raddr_r1),
    .rdata0_r (rdr0),
    .rdata1_r (rdr1)
  );

  // Size register and clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= SIZE_RESET;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_data;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
    end
  end

  // Pending read flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl0_r <= 1'b0;
      pl1_r <= 1'b0;
      pr0_r <= 1'b0;
      pr1_r <= 1'b0;
    end else begin
      pl0_r <= rdl0_v;
      pl1_r <= rdl1_v;
      pr0_r <= rdr0_v;
      pr1_r <= rdr1_v;
    end
  end

  // Load a request, advance the path update or the range walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r   <= IDX_W'(leaf);
      first_r <= 1'b1;
      vl_r    <= VAL_W'(in_data.price) - VAL_W'(in_data.position);
      vr_r    <= VAL_W'(in_data.price) + VAL_W'(in_data.position);
      qpos_r  <= in_data.position;
      bestl_r <= EMPTY_MARK;
      bestr_r <= EMPTY_MARK;
      if (in_range) begin
        al_r <= BW'(MAX_POSITIONS);
        bl_r <= leaf + BW'(1);
        ar_r <= leaf;
        br_r <= BW'(MAX_POSITIONS) + BW'(n_act);
      end else begin
        al_r <= '0;
        bl_r <= '0;
        ar_r <= '0;
        br_r <= '0;
      end
    end else begin
      if (cmd.upd_step) begin
        idx_r   <= idx_r >> 1;
        first_r <= 1'b0;
        vl_r    <= wval_l;
        vr_r    <= wval_r;
      end
      if (cmd.qry_step) begin
        al_r <= (al_r >> 1) + BW'(al_r[0]);
        bl_r <= bl_r >> 1;
        ar_r <= (ar_r >> 1) + BW'(ar_r[0]);
        br_r <= br_r >> 1;
      end
      // Fold in node reads issued in the previous cycle
      case ({pl0_r, pl1_r})
        2'b10:   bestl_r <= min_val(bestl_r, rdl0);
        2'b01:   bestl_r <= min_val(bestl_r, rdl1);
        2'b11:   bestl_r <= min_val(bestl_r, min_val(rdl0, rdl1));
        default: bestl_r <= bestl_r;
      endcase
      case ({pr0_r, pr1_r})
        2'b10:   bestr_r <= min_val(bestr_r, rdr0);
        2'b01:   bestr_r <= min_val(bestr_r, rdr1);
        2'b11:   bestr_r <= min_val(bestr_r, min_val(rdr0, rdr1));
        default: bestr_r <= bestr_r;
      endcase
    end
  end

  // Combine both sides into the weighted cost
  always_comb begin
    have_l = bestl_r != EMPTY_MARK;
    have_r = bestr_r != EMPTY_MARK;
    cand_l = SUM_W'(bestl_r) + $signed(SUM_W'(qpos_r));
    cand_r = SUM_W'(bestr_r) - $signed(SUM_W'(qpos_r));
    if (have_l && !(have_r && (cand_r < cand_l))) begin
      cand_best = cand_l;
    end else begin
      cand_best = cand_r;
    end
  end

  // Hold the result for the output side
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (!(have_l || have_r)) begin
        out_r.best_cost <= '0;
        out_r.no_answer <= 1'b1;
      end else begin
        out_r.best_cost <= cand_best[SUM_W-1] ? '0 : cand_best[COST_W-1:0];
        out_r.no_answer <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.clr_last   = clr_cnt_r == IDX_W'(NODES - 1);
    stat.in_range   = in_range;
    stat.at_root    = idx_r == IDX_W'(1);
    stat.qry_active = act_l | act_r;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

/* rtl/dwrm_ctrl.sv */
// Controller: clearing pass, request sequencing and result hand-off.
`default_nettype none

module dwrm_ctrl import dwrm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_mode,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dwrm_stat_t stat,
  output dwrm_cmd_t       cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_QRY   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, out_free;

  always_comb begin
    in_ready     = state_r == S_IDLE;
    accept       = in_valid & in_ready;
    out_free     = !out_valid_r | out_ready;
    cmd.clr_step = state_r == S_CLEAR;
    cmd.load     = accept;
    cmd.upd_step = state_r == S_UPD;
    cmd.qry_step = state_r == S_QRY;
    cmd.out_load = (state_r == S_FIN) & out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_QUERY) begin
            state_nxt = S_QRY;
          end else if (stat.in_range) begin
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        if (stat.at_root) begin
          state_nxt = S_IDLE;
        end
      end
      S_QRY: begin
        if (!stat.qry_active) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result valid until it is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_clear_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && !stat.clr_last) |=> state_r == S_CLEAR)
    else $error("clearing pass left early");

  a_root_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && stat.at_root) |=> state_r == S_IDLE)
    else $error("path update ran past the root");

  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QRY && !stat.qry_active) |=> state_r == S_FIN)
    else $error("range walk did not finish");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("query result not presented");

endmodule

`default_nettype wire

/* rtl/distance_weighted_range_min.sv */
// Top level of the distance weighted range minimum block.
`default_nettype none

// Keeps a price per position 1..size_in_use in two minimum trees (price minus
// position and price plus position), each a node memory of 2*MAX_POSITIONS
// entries with one write and two read ports. A write request walks from the
// leaf to the root one level a cycle and gives no result. A query walks both
// range bounds up the trees, reading up to two nodes per tree each cycle, and
// gives one result with best_cost and no_answer. After reset a clearing pass
// writes the empty marker into every node; in_ready stays low during it.
// Configuration writes are always ready and must be made while the block is
// idle. A finished result is held in an output register, so a new request is
// taken while it waits.
module distance_weighted_range_min import dwrm_pkg::*; #(
  parameter int MAX_POSITIONS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dwrm_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dwrm_out_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] cfg_data
);

  dwrm_cmd_t  cmd;
  dwrm_stat_t stat;

  assign cfg_ready = 1'b1;

  dwrm_datapath #(.MAX_POSITIONS(MAX_POSITIONS)) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  dwrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

endmodule

`default_nettype wire

/* tb/dwrm_result_checker.sv */
// Channel monitor with its own price table: predicts each query and checks it.
`timescale 1ns / 100ps

module dwrm_result_checker import dwrm_pkg::*; #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  dwrm_in_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  dwrm_out_t         out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data,
  output int                error_count,
  output int                results_owed
);

  // Own copy of the table and the size register
  logic [PRICE_W-1:0] price_at   [1:MAX_POSITIONS];
  bit                 price_held [1:MAX_POSITIONS];
  logic [SIZE_W-1:0]  size_reg;
  dwrm_out_t          awaited_costs [$];

  // Clamp the size register to the table depth
  function automatic int positions_in_use();
    return (size_reg > MAX_POSITIONS) ? MAX_POSITIONS : int'(size_reg);
  endfunction

  // Cheapest stored price plus distance to pos, over positions 1..size
  function automatic dwrm_out_t nearest_weighted_cost(input logic [POS_W-1:0] pos);
    int        n;
    int        k;
    longint    best;
    longint    cost;
    bit        found;
    dwrm_out_t res;
    n             = positions_in_use();
    k             = int'(pos);
    best          = 0;
    found         = 1'b0;
    res.best_cost = '0;
    res.no_answer = 1'b1;
    if (k >= 1 && k <= n) begin
      for (int j = 1; j <= n; j++) begin
        if (price_held[j]) begin
          cost = longint'(price_at[j]) + ((j > k) ? longint'(j - k) : longint'(k - j));
          if (!found || cost < best) begin
            best = cost;
          end
          found = 1'b1;
        end
      end
      if (found) begin
        res.best_cost = best[COST_W-1:0];
        res.no_answer = 1'b0;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    dwrm_out_t want;
    int        n;
    if (!rst_n) begin
      size_reg = SIZE_RESET;
      for (int j = 1; j <= MAX_POSITIONS; j++) begin
        price_held[j] = 1'b0;
      end
      awaited_costs.delete();
      error_count = 0;
    end else begin
      // Compare a finished result with the oldest query
      if (out_valid && out_ready) begin
        if (awaited_costs.size() == 0) begin
          $error("unexpected result: best_cost %0d, no_answer %0d",
                 out_data.best_cost, out_data.no_answer);
          error_count++;
        end else begin
          want = awaited_costs.pop_front();
          if (out_data.best_cost !== want.best_cost) begin
            $error("best_cost: expected %0d, got %0d", want.best_cost, out_data.best_cost);
            error_count++;
          end
          if (out_data.no_answer !== want.no_answer) begin
            $error("no_answer: expected %0d, got %0d", want.no_answer, out_data.no_answer);
            error_count++;
          end
        end
      end
      // Track the size register
      if (cfg_valid && cfg_ready) begin
        size_reg = cfg_data;
      end
      // Apply a write request or predict a query
      if (in_valid && in_ready) begin
        n = positions_in_use();
        if (in_data.mode == MODE_WRITE) begin
          if (in_data.position >= 1 && int'(in_data.position) <= n) begin
            price_at[in_data.position]   = in_data.price;
            price_held[in_data.position] = 1'b1;
          end
        end else begin
          awaited_costs.push_back(nearest_weighted_cost(in_data.position));
        end
      end
    end
    results_owed = awaited_costs.size();
  end

endmodule

/* tb/tb_distance_weighted_range_min.sv */
// Stimulus, flow control and verdict for the distance weighted range minimum block.
`timescale 1ns / 100ps

module tb_distance_weighted_range_min;
  import dwrm_pkg::*;

  localparam int MAX_POSITIONS = 1024;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES  = 30;
  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  dwrm_in_t          in_data;
  logic              out_valid;
  logic              out_ready;
  dwrm_out_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data;

  int idle_pct;
  int stall_pct;
  int hold_seq;
  int size_now;
  int error_count;
  int results_owed;

  distance_weighted_range_min #(
    .MAX_POSITIONS(MAX_POSITIONS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  dwrm_result_checker #(
    .MAX_POSITIONS(MAX_POSITIONS)
  ) result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    #3_000_000;
    $display("tb_distance_weighted_range_min: done, errors");
    $finish;
  end

  // Drive out_ready: random stalls, plus a long hold-off on request
  initial begin
    int hold_done;
    hold_done = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = hold_seq;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one request after a random gap; return at the falling edge after acceptance
  task automatic send_request(input dwrm_in_t req);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_price(input int pos, input logic [PRICE_W-1:0] price);
    dwrm_in_t req;
    req.mode     = MODE_WRITE;
    req.position = POS_W'(pos);
    req.price    = price;
    send_request(req);
  endtask

  task automatic query_at(input int pos);
    dwrm_in_t req;
    req.mode     = MODE_QUERY;
    req.position = POS_W'(pos);
    req.price    = PRICE_W'($urandom_range(1023));
    send_request(req);
  endtask

  // Drain, let queued writes settle, then write the size register
  task automatic set_size(input logic [SIZE_W-1:0] value);
    in_valid <= 1'b0;
    wait (results_owed == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    size_now   = int'(value);
  endtask

  // Mostly positions in use, some at the edges, some anywhere in the field
  function automatic int random_position();
    int n;
    int r;
    n = (size_now > MAX_POSITIONS) ? MAX_POSITIONS : size_now;
    r = $urandom_range(99);
    if (r < 15) begin
      return $urandom_range(2047);
    end
    if (r < 25) begin
      case ($urandom_range(3))
        0:       return 0;
        1:       return 1;
        2:       return n;
        default: return n + 1;
      endcase
    end
    if (n == 0) begin
      return $urandom_range(3);
    end
    return $urandom_range(n, 1);
  endfunction

  function automatic dwrm_in_t random_request();
    dwrm_in_t    req;
    logic [31:0] raw;
    int          r;
    raw          = $urandom();
    r            = $urandom_range(99);
    req.mode     = ($urandom_range(99) < 50) ? MODE_WRITE : MODE_QUERY;
    req.position = POS_W'(random_position());
    if (r < 40) begin
      req.price = raw[PRICE_W-1:0];
    end else if (r < 80) begin
      req.price = PRICE_W'($urandom_range(2000));
    end else if (r < 90) begin
      req.price = '0;
    end else begin
      req.price = PRICE_MAX;
    end
    return req;
  endfunction

  task automatic run_phase(input logic [SIZE_W-1:0] size, input int idle, input int stall,
                           input int count);
    set_size(size);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) send_request(random_request());
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_seq  = 0;
    size_now  = int'(SIZE_RESET);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table and positions out of range
    query_at(1);
    query_at(0);
    query_at(1025);
    query_at(2047);
    write_price(0, 7);
    write_price(1025, 7);
    write_price(2047, 0);
    query_at(1024);

    // One side empty, then both sides, then an overwrite
    write_price(1024, PRICE_MAX);
    query_at(1);
    write_price(1, 0);
    query_at(1024);
    query_at(1);
    write_price(512, 5);
    query_at(512);
    query_at(600);
    query_at(400);
    write_price(512, PRICE_MAX);
    query_at(512);
    write_price(682, 30'h2AAA_AAAA);
    write_price(341, 30'h1555_5555);
    query_at(682);
    query_at(1023);

    // Sweep size settings and flow-control mixes
    run_phase(11'd1,    0,  0,  60);
    run_phase(11'd2,    57, 0,  60);
    run_phase(11'd0,    0,  57, 40);
    run_phase(11'd2047, 0,  57, 180);
    run_phase(11'd16,   34, 34, 140);

    // Hold the result side off while queries keep coming
    set_size(11'd1024);
    idle_pct  = 0;
    stall_pct = 0;
    hold_seq++;
    repeat (20) query_at(random_position());
    repeat (180) send_request(random_request());

    run_phase(11'd700,  34, 34, 140);
    run_phase(11'd5,    57, 0,  60);
    run_phase(11'd1024, 0,  57, 50);

    in_valid <= 1'b0;
    wait (results_owed == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && results_owed == 0) begin
      $display("tb_distance_weighted_range_min: done, clean");
    end else begin
      $display("tb_distance_weighted_range_min: done, errors");
    end
    $finish;
  end

endmodule
